// File: hdl/segx_pkg.sv
// shared constants and types for the segment crossing test
`timescale 1ns / 1ps

package segx_pkg;

  // width of every coordinate port
  localparam int FIELD_W = 32;

  // default number of coordinate bits in use
  localparam int COORD_WIDTH_DEF = 32;

  // depths of the queue between front and back and of the result queue
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // slot layout of the item handed from front to back, one difference per slot
  localparam int SLOT_EX  = 0;   // four point offsets, x
  localparam int SLOT_EY  = 4;   // four point offsets, y
  localparam int SLOT_DAX = 8;   // direction of segment a
  localparam int SLOT_DAY = 9;
  localparam int SLOT_DBX = 10;  // direction of segment b
  localparam int SLOT_DBY = 11;
  localparam int N_SLOTS  = 12;

  // classification flags worked out by the front
  typedef struct packed {
    logic       box_ok;   // bounding boxes overlap
    logic [3:0] ext_ok;   // point within extent and not an endpoint
  } seg_class_t;

  localparam int CLASS_W = $bits(seg_class_t);

endpackage

// File: hdl/segx_fifo.sv
// small register queue with count, used between stages and at the result side
`timescale 1ns / 1ps

module segx_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // fill level stays within the storage
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(Depth))
    else $error("queue count beyond depth");

endmodule

// File: hdl/segx_front.sv
// front stage: takes a segment pair, checks boxes and extents, forms differences
`timescale 1ns / 1ps

module segx_front #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
  parameter int PAY_W = segx_pkg::CLASS_W + segx_pkg::N_SLOTS * (COORD_WIDTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [segx_pkg::FIELD_W-1:0] a_start_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_start_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_end_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_end_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_start_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_start_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_end_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_end_y_i,
  output logic                        mid_push_o,
  output logic [PAY_W-1:0]            mid_data_o,
  input  logic                        mid_full_i
);

  localparam int DIFF_W = COORD_WIDTH + 1;

  // endpoints: 0 a start, 1 a end, 2 b start, 3 b end
  logic signed [COORD_WIDTH-1:0] px [4];
  logic signed [COORD_WIDTH-1:0] py [4];
  logic signed [DIFF_W-1:0]      wx [4];
  logic signed [DIFF_W-1:0]      wy [4];
  logic signed [DIFF_W-1:0]      ex [4];
  logic signed [DIFF_W-1:0]      ey [4];
  segx_pkg::seg_class_t          cls;
  logic                          lo_x, lo_y, hi_x, hi_y;
  logic [PAY_W-1:0]              pay_d, pay_q;
  logic                          valid_q, valid_d;
  logic                          accept;

  function automatic logic between(logic signed [COORD_WIDTH-1:0] p,
                                   logic signed [COORD_WIDTH-1:0] s,
                                   logic signed [COORD_WIDTH-1:0] t);
    between = (p >= s && p <= t) || (p <= s && p >= t);
  endfunction

  // point p strictly inside segment s..t, apart from the collinearity check
  function automatic logic ext_check(logic [1:0] p, logic [1:0] s, logic [1:0] t,
                                     logic signed [COORD_WIDTH-1:0] cx [4],
                                     logic signed [COORD_WIDTH-1:0] cy [4]);
    logic at_end;
    at_end    = (cx[p] == cx[s] && cy[p] == cy[s]) || (cx[p] == cx[t] && cy[p] == cy[t]);
    ext_check = !at_end && between(cx[p], cx[s], cx[t]) && between(cy[p], cy[s], cy[t]);
  endfunction

  assign px[0] = $signed(a_start_x_i[COORD_WIDTH-1:0]);
  assign py[0] = $signed(a_start_y_i[COORD_WIDTH-1:0]);
  assign px[1] = $signed(a_end_x_i[COORD_WIDTH-1:0]);
  assign py[1] = $signed(a_end_y_i[COORD_WIDTH-1:0]);
  assign px[2] = $signed(b_start_x_i[COORD_WIDTH-1:0]);
  assign py[2] = $signed(b_start_y_i[COORD_WIDTH-1:0]);
  assign px[3] = $signed(b_end_x_i[COORD_WIDTH-1:0]);
  assign py[3] = $signed(b_end_y_i[COORD_WIDTH-1:0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wx[i] = DIFF_W'(px[i]);
      wy[i] = DIFF_W'(py[i]);
    end
    // offsets of the tested point from the start of its segment
    ex[0] = wx[2] - wx[0];
    ey[0] = wy[2] - wy[0];
    ex[1] = wx[3] - wx[0];
    ey[1] = wy[3] - wy[0];
    ex[2] = wx[0] - wx[2];
    ey[2] = wy[0] - wy[2];
    ex[3] = wx[1] - wx[2];
    ey[3] = wy[1] - wy[2];

    // min(a) <= max(b) holds when some a coordinate is at most some b coordinate
    lo_x = (px[0] <= px[2]) || (px[0] <= px[3]) || (px[1] <= px[2]) || (px[1] <= px[3]);
    lo_y = (py[0] <= py[2]) || (py[0] <= py[3]) || (py[1] <= py[2]) || (py[1] <= py[3]);
    hi_x = (px[0] >= px[2]) || (px[0] >= px[3]) || (px[1] >= px[2]) || (px[1] >= px[3]);
    hi_y = (py[0] >= py[2]) || (py[0] >= py[3]) || (py[1] >= py[2]) || (py[1] >= py[3]);

    cls.box_ok    = lo_x && lo_y && hi_x && hi_y;
    cls.ext_ok[0] = ext_check(2'd2, 2'd0, 2'd1, px, py);
    cls.ext_ok[1] = ext_check(2'd3, 2'd0, 2'd1, px, py);
    cls.ext_ok[2] = ext_check(2'd0, 2'd2, 2'd3, px, py);
    cls.ext_ok[3] = ext_check(2'd1, 2'd2, 2'd3, px, py);

    pay_d = '0;
    for (int i = 0; i < 4; i++) begin
      pay_d[(segx_pkg::SLOT_EX + i) * DIFF_W +: DIFF_W] = ex[i];
      pay_d[(segx_pkg::SLOT_EY + i) * DIFF_W +: DIFF_W] = ey[i];
    end
    pay_d[segx_pkg::SLOT_DAX * DIFF_W +: DIFF_W] = wx[1] - wx[0];
    pay_d[segx_pkg::SLOT_DAY * DIFF_W +: DIFF_W] = wy[1] - wy[0];
    pay_d[segx_pkg::SLOT_DBX * DIFF_W +: DIFF_W] = wx[3] - wx[2];
    pay_d[segx_pkg::SLOT_DBY * DIFF_W +: DIFF_W] = wy[3] - wy[2];
    pay_d[segx_pkg::N_SLOTS * DIFF_W +: segx_pkg::CLASS_W] = cls;
  end

  assign full_o     = valid_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = valid_q;
  assign mid_data_o = pay_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !mid_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_q <= pay_d;
    end
  end

endmodule

// File: hdl/segx_back.sv
// back stages: cross products, orientation signs and the final decision
`timescale 1ns / 1ps

module segx_back #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
  parameter int PAY_W = segx_pkg::CLASS_W + segx_pkg::N_SLOTS * (COORD_WIDTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PAY_W-1:0] mid_data_i,
  input  logic             mid_empty_i,
  output logic             mid_pop_o,
  output logic             res_push_o,
  output logic             res_cross_o,
  input  logic             res_full_i
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  logic signed [DIFF_W-1:0] ex [4];
  logic signed [DIFF_W-1:0] ey [4];
  logic signed [DIFF_W-1:0] dx [4];
  logic signed [DIFF_W-1:0] dy [4];
  segx_pkg::seg_class_t     cls_in;

  logic                     s1_valid_q;
  segx_pkg::seg_class_t     s1_cls_q;
  logic signed [PROD_W-1:0] p_q [4];
  logic signed [PROD_W-1:0] q_q [4];

  logic                     s2_valid_q;
  logic                     s2_cross_q;
  logic                     s2_cross_d;

  logic [3:0]               pos, neg;
  logic                     adv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ex[i] = $signed(mid_data_i[(segx_pkg::SLOT_EX + i) * DIFF_W +: DIFF_W]);
      ey[i] = $signed(mid_data_i[(segx_pkg::SLOT_EY + i) * DIFF_W +: DIFF_W]);
      if (i < 2) begin
        dx[i] = $signed(mid_data_i[segx_pkg::SLOT_DAX * DIFF_W +: DIFF_W]);
        dy[i] = $signed(mid_data_i[segx_pkg::SLOT_DAY * DIFF_W +: DIFF_W]);
      end else begin
        dx[i] = $signed(mid_data_i[segx_pkg::SLOT_DBX * DIFF_W +: DIFF_W]);
        dy[i] = $signed(mid_data_i[segx_pkg::SLOT_DBY * DIFF_W +: DIFF_W]);
      end
    end
    cls_in = segx_pkg::seg_class_t'(mid_data_i[segx_pkg::N_SLOTS * DIFF_W +:
                                               segx_pkg::CLASS_W]);
  end

  // whole pipe freezes only when the finished item cannot leave
  assign adv       = !(s2_valid_q && res_full_i);
  assign mid_pop_o = adv && !mid_empty_i;

  // orientation sign of d x e, from the two registered products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pos[i] = p_q[i] > q_q[i];
      neg[i] = p_q[i] < q_q[i];
    end
    s2_cross_d = s1_cls_q.box_ok &&
                 ((|(s1_cls_q.ext_ok & ~pos & ~neg)) ||
                  (((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
                   ((pos[2] && neg[3]) || (neg[2] && pos[3]))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= mid_pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cls_q <= cls_in;
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= dx[i] * ey[i];
        q_q[i] <= ex[i] * dy[i];
      end
      s2_cross_q <= s2_cross_d;
    end
  end

  assign res_push_o  = s2_valid_q;
  assign res_cross_o = s2_cross_q;

  // a result blocked by a full result queue waits unchanged
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && res_full_i) |=> (s2_valid_q && $stable(s2_cross_q)))
    else $error("blocked result changed");

endmodule

// File: hdl/segment_crossing_test.sv
// top level of the segment crossing test: front, mid queue, back, result queue
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// input     in         push / full             a_start/a_end/b_start/b_end x,y (32 bit)
// result    out        empty / pop             crosses_o (1 bit)
//
// one pair per cycle when no queue is full, set by the back's eight multipliers
// items pass the front register, mid queue, back products, decision, result queue
// rst_ni clears all valid flags and queue counts at once, no clearing pass
// full rises when the front holds an item and the mid queue is full
// a full result queue freezes the back; the front can still fill the mid queue
module segment_crossing_test #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [segx_pkg::FIELD_W-1:0] a_start_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_start_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_end_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] a_end_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_start_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_start_y_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_end_x_i,
  input  logic [segx_pkg::FIELD_W-1:0] b_end_y_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         crosses_o
);

  // item between front and back: class flags plus twelve differences
  localparam int PAY_W = segx_pkg::CLASS_W + segx_pkg::N_SLOTS * (COORD_WIDTH + 1);

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [PAY_W-1:0] mid_wdata, mid_rdata;
  logic             res_push, res_cross, res_full;

  // front: bounding boxes, extents, endpoint exclusion, differences
  segx_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .PAY_W       (PAY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .mid_push_o  (mid_push),
    .mid_data_o  (mid_wdata),
    .mid_full_i  (mid_full)
  );

  // short queue decoupling the front from the back
  segx_fifo #(
    .Width (PAY_W),
    .Depth (segx_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // back: exact cross products, then signs and the decision
  segx_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .PAY_W       (PAY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mid_rdata),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_cross_o (res_cross),
    .res_full_i  (res_full)
  );

  // result queue, its head drives the result ports
  segx_fifo #(
    .Width (1),
    .Depth (segx_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_cross),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (crosses_o),
    .empty_o (empty)
  );

  // back never pulls from an empty mid queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_pop && mid_empty))
    else $error("pop from empty mid queue");

  // a result held back by a full result queue is still offered next cycle
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_full) |=> res_push)
    else $error("blocked result dropped");

  // an item held in the front while the mid queue is full stays held
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && mid_full) |=> (mid_push))
    else $error("front item lost while stalled");

endmodule

// File: verif/tb_segment_crossing_test.sv
// self-checking testbench for the segment crossing test block
`timescale 1ns / 1ps

module tb_segment_crossing_test;

  localparam int FW        = segx_pkg::FIELD_W;
  localparam int COORD_W   = segx_pkg::COORD_WIDTH_DEF;
  localparam int RAND_ITEMS = 1700;
  localparam int PHASE_LEN  = 100;
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off to back the block up
  localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 20;     // quiet tail after the last answer, room for strays

  localparam logic [FW-1:0] C_MIN = 32'h8000_0000;
  localparam logic [FW-1:0] C_MAX = 32'h7fff_ffff;
  localparam logic [FW-1:0] C_A5  = 32'haaaa_aaaa;
  localparam logic [FW-1:0] C_55  = 32'h5555_5555;

  // one item: two segments, each a start and an end point
  typedef struct packed {
    logic [FW-1:0] asx, asy, atx, aty;
    logic [FW-1:0] bsx, bsy, btx, bty;
  } seg_pair_t;

  // where a directed row gets its expected answer from
  typedef enum logic {EXP_PREDICTED, EXP_TYPED} exp_src_e;

  typedef struct packed {
    seg_pair_t pair;
    exp_src_e  src;
    logic      crosses;
  } pair_row_t;

  localparam int DIR_ROWS = 23;

  // directed rows; answers typed in only where they are obvious
  pair_row_t dir_rows [DIR_ROWS] = '{
    // plain x shaped crossing
    '{'{0, 0, 10, 10, 0, 10, 10, 0}, EXP_TYPED, 1'b1},
    // bounding boxes apart
    '{'{0, 0, 1, 1, 5, 5, 6, 7}, EXP_TYPED, 1'b0},
    // touching at a shared endpoint only
    '{'{0, 0, 5, 5, 5, 5, 10, 0}, EXP_TYPED, 1'b0},
    // identical collinear segments, same and reversed direction
    '{'{-3, 2, 7, 2, -3, 2, 7, 2}, EXP_TYPED, 1'b0},
    '{'{-3, 2, 7, 2, 7, 2, -3, 2}, EXP_TYPED, 1'b0},
    // t junction, b start on the inside of a
    '{'{0, 0, 10, 0, 5, 0, 5, 5}, EXP_TYPED, 1'b1},
    // b end on the inside of a
    '{'{0, 0, 10, 0, 5, -5, 5, 0}, EXP_PREDICTED, 1'b0},
    // a end on the inside of b
    '{'{0, 8, 4, 4, 0, 0, 8, 8}, EXP_PREDICTED, 1'b0},
    // collinear, overlapping
    '{'{0, 0, 10, 0, 5, 0, 15, 0}, EXP_TYPED, 1'b1},
    // collinear, end to end
    '{'{0, 0, 5, 0, 5, 0, 10, 0}, EXP_TYPED, 1'b0},
    // degenerate a, lying on b and off b
    '{'{3, 3, 3, 3, 0, 0, 6, 6}, EXP_PREDICTED, 1'b0},
    '{'{3, 4, 3, 4, 0, 0, 6, 6}, EXP_PREDICTED, 1'b0},
    // both degenerate on the same point
    '{'{2, 2, 2, 2, 2, 2, 2, 2}, EXP_TYPED, 1'b0},
    // parallel and offset
    '{'{0, 0, 10, 0, 0, 1, 10, 1}, EXP_TYPED, 1'b0},
    // near miss, overlapping boxes
    '{'{0, 0, 10, 10, 6, 4, 10, 0}, EXP_PREDICTED, 1'b0},
    // full range diagonals
    '{'{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN}, EXP_TYPED, 1'b1},
    // every coordinate at one extreme
    '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, EXP_TYPED, 1'b0},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, EXP_TYPED, 1'b0},
    // full range axes
    '{'{C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX}, EXP_TYPED, 1'b1},
    // collinear with products near the top of the range
    '{'{C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 1, 1}, EXP_PREDICTED, 1'b0},
    // off collinear by one unit over the full range
    '{'{C_MIN, C_MIN, C_MAX, 32'h7fff_fffe, 0, 0, 5, -7}, EXP_PREDICTED, 1'b0},
    // alternating bit patterns
    '{'{C_55, C_A5, C_A5, C_55, C_A5, C_A5, C_55, C_55}, EXP_PREDICTED, 1'b0},
    '{'{C_A5, C_55, C_55, C_A5, C_55, C_55, C_A5, C_A5}, EXP_PREDICTED, 1'b0}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          push;
  logic          full;
  logic [FW-1:0] a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i;
  logic [FW-1:0] b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i;
  logic          empty;
  logic          pop;
  logic          crosses_o;

  // expected crossing flags, oldest first
  logic crossing_q [$];
  int   mismatch_count;

  // knobs set by the sender; the rx ones steer the receiver
  bit tx_no_idle;
  bit rx_no_idle;
  bit rx_hold_req;

  segment_crossing_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .empty       (empty),
    .pop         (pop),
    .crosses_o   (crosses_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor: exact integer geometry at 128 bits, no overflow possible
  // ---------------------------------------------------------------------------

  // only the low COORD_W bits count, sign extended from the top one
  function automatic longint coord_value(logic [FW-1:0] raw);
    logic signed [63:0] w;
    w = signed'({32'b0, raw} << (64 - COORD_W));
    return w >>> (64 - COORD_W);
  endfunction

  // sign of ax*by - bx*ay
  function automatic int turn_sign(longint ax, longint ay, longint bx, longint by);
    logic signed [127:0] wax, way, wbx, wby, lhs, rhs;
    wax = ax;
    way = ay;
    wbx = bx;
    wby = by;
    lhs = wax * wby;
    rhs = wbx * way;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // point p on segment s..t, endpoints excluded
  function automatic bit on_interior(longint sx, longint sy, longint tx, longint ty,
                                     longint px, longint py);
    longint dx, dy, ex, ey;
    if ((px == tx && py == ty) || (px == sx && py == sy)) return 1'b0;
    dx = tx - sx;
    dy = ty - sy;
    ex = px - sx;
    ey = py - sy;
    if (turn_sign(dx, dy, ex, ey) != 0) return 1'b0;
    if (sign_of(dx) * sign_of(ex) < 0) return 1'b0;
    if (sign_of(dy) * sign_of(ey) < 0) return 1'b0;
    if (magnitude(dx) < magnitude(ex)) return 1'b0;
    if (magnitude(dy) < magnitude(ey)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint lo_of(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi_of(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic pair_crosses(seg_pair_t p);
    longint asx, asy, atx, aty, bsx, bsy, btx, bty;
    int     s1, s2;
    asx = coord_value(p.asx);
    asy = coord_value(p.asy);
    atx = coord_value(p.atx);
    aty = coord_value(p.aty);
    bsx = coord_value(p.bsx);
    bsy = coord_value(p.bsy);
    btx = coord_value(p.btx);
    bty = coord_value(p.bty);
    // boxes apart means no crossing
    if (lo_of(asx, atx) > hi_of(bsx, btx)) return 1'b0;
    if (lo_of(asy, aty) > hi_of(bsy, bty)) return 1'b0;
    if (hi_of(asx, atx) < lo_of(bsx, btx)) return 1'b0;
    if (hi_of(asy, aty) < lo_of(bsy, bty)) return 1'b0;
    // an endpoint on the inside of the other segment counts as a crossing
    if (on_interior(asx, asy, atx, aty, bsx, bsy)) return 1'b1;
    if (on_interior(asx, asy, atx, aty, btx, bty)) return 1'b1;
    if (on_interior(bsx, bsy, btx, bty, asx, asy)) return 1'b1;
    if (on_interior(bsx, bsy, btx, bty, atx, aty)) return 1'b1;
    // proper crossing: both orientation pairs strictly opposite
    s1 = turn_sign(atx - asx, aty - asy, bsx - asx, bsy - asy);
    s2 = turn_sign(atx - asx, aty - asy, btx - asx, bty - asy);
    if (s1 * s2 >= 0) return 1'b0;
    s1 = turn_sign(btx - bsx, bty - bsy, asx - bsx, asy - bsy);
    s2 = turn_sign(btx - bsx, bty - bsy, atx - bsx, aty - bsy);
    return (s1 * s2 < 0);
  endfunction

  // ---------------------------------------------------------------------------
  // random pairs
  // ---------------------------------------------------------------------------

  // large base point, zero now and then
  function automatic int pick_base();
    if ($urandom_range(0, 3) == 0) return 0;
    return int'($urandom) >>> 1;
  endfunction

  function automatic int jitter(int base);
    return base + int'($urandom_range(0, 16)) - 8;
  endfunction

  function automatic logic [FW-1:0] extreme_value();
    case ($urandom_range(0, 7))
      0: return C_MIN;
      1: return C_MAX;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hffff_ffff;
      5: return C_MIN + 1;
      6: return C_MAX - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    seg_pair_t q;
    int        px, py, dx, dy, step, k, j, kind;
    kind = $urandom_range(0, 99);
    px   = pick_base();
    py   = pick_base();
    dx   = int'($urandom_range(0, 14)) - 7;
    dy   = int'($urandom_range(0, 14)) - 7;
    step = 1 << $urandom_range(0, 22);
    if (kind < 15) begin
      // noise over the whole field range
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 45) begin
      // all four points in a small box, many touching and collinear cases
      p.asx = jitter(px); p.asy = jitter(py); p.atx = jitter(px); p.aty = jitter(py);
      p.bsx = jitter(px); p.bsy = jitter(py); p.btx = jitter(px); p.bty = jitter(py);
    end else if (kind < 70) begin
      // four points on one line, at multiples of a scaled direction
      p.asx = px + (int'($urandom_range(0, 8)) - 4) * step * dx;
      p.asy = py + (int'($urandom_range(0, 8)) - 4) * step * dy;
      k = int'($urandom_range(0, 8)) - 4;
      p.atx = px + k * step * dx; p.aty = py + k * step * dy;
      k = int'($urandom_range(0, 8)) - 4;
      p.bsx = px + k * step * dx; p.bsy = py + k * step * dy;
      k = int'($urandom_range(0, 8)) - 4;
      p.btx = px + k * step * dx; p.bty = py + k * step * dy;
      // now and then pull the y of one point off the line by one
      if ($urandom_range(0, 3) == 0) p.bty = p.bty + 1;
    end else if (kind < 85) begin
      // b starts somewhere along a, endpoints included
      k = $urandom_range(2, 6);
      j = $urandom_range(0, k);
      p.asx = px;                 p.asy = py;
      p.atx = px + k * step * dx; p.aty = py + k * step * dy;
      p.bsx = px + j * step * dx; p.bsy = py + j * step * dy;
      p.btx = p.bsx + (int'($urandom_range(0, 16)) - 8) * step;
      p.bty = p.bsy + (int'($urandom_range(0, 16)) - 8) * step;
    end else begin
      p = {extreme_value(), extreme_value(), extreme_value(), extreme_value(),
           extreme_value(), extreme_value(), extreme_value(), extreme_value()};
    end
    // shuffle roles so every endpoint and axis sees every construction
    q = p;
    if ($urandom_range(0, 1)) begin
      q.asx = p.bsx; q.asy = p.bsy; q.atx = p.btx; q.aty = p.bty;
      q.bsx = p.asx; q.bsy = p.asy; q.btx = p.atx; q.bty = p.aty;
    end
    p = q;
    if ($urandom_range(0, 1)) begin
      q.asx = p.atx; q.asy = p.aty; q.atx = p.asx; q.aty = p.asy;
    end
    if ($urandom_range(0, 1)) begin
      q.bsx = p.btx; q.bsy = p.bty; q.btx = p.bsx; q.bty = p.bsy;
    end
    p = q;
    if ($urandom_range(0, 1)) begin
      q.asx = p.asy; q.asy = p.asx; q.atx = p.aty; q.aty = p.atx;
      q.bsx = p.bsy; q.bsy = p.bsx; q.btx = p.bty; q.bty = p.btx;
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  function automatic int tx_gap();
    return tx_no_idle ? 0 : int'($urandom_range(0, 19));
  endfunction

  // offer one item and hold it until the block takes it; returns at the taking edge
  task automatic offer_pair(input seg_pair_t p, input logic exp_crosses, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    a_start_x_i <= p.asx;
    a_start_y_i <= p.asy;
    a_end_x_i   <= p.atx;
    a_end_y_i   <= p.aty;
    b_start_x_i <= p.bsx;
    b_start_y_i <= p.bsy;
    b_end_x_i   <= p.btx;
    b_end_y_i   <= p.bty;
    push        <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    crossing_q.push_back(exp_crosses);
  endtask

  // stop offering until every expected item has come back
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (crossing_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    seg_pair_t p;
    int        phase;
    // every input known from time zero, reset held low
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    a_start_x_i = '0;
    a_start_y_i = '0;
    a_end_x_i   = '0;
    a_end_y_i   = '0;
    b_start_x_i = '0;
    b_start_y_i = '0;
    b_end_x_i   = '0;
    b_end_y_i   = '0;
    tx_no_idle  = 1'b0;
    rx_no_idle  = 1'b0;
    rx_hold_req = 1'b0;
    mismatch_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_pair(dir_rows[r].pair,
                 (dir_rows[r].src == EXP_TYPED) ? dir_rows[r].crosses
                                                : pair_crosses(dir_rows[r].pair),
                 tx_gap());
    end
    drain_results();

    // random phases with changing idle patterns
    for (phase = 0; phase * PHASE_LEN < RAND_ITEMS; phase++) begin
      tx_no_idle = (phase % 4 == 1) || (phase == 3);
      rx_no_idle = (phase % 4 == 1) || (phase % 4 == 2);
      // one phase floods the block while the receiver sits still
      if (phase == 3) rx_hold_req = 1'b1;
      for (int i = 0; i < PHASE_LEN; i++) begin
        p = random_pair();
        offer_pair(p, pair_crosses(p), tx_gap());
      end
      if (phase % 5 == 4) drain_results();
    end

    // all items in, wait for the answers and a short quiet tail
    push <= 1'b0;
    while (crossing_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: pops with random stalls, checks against the oldest expectation
  // ---------------------------------------------------------------------------

  initial begin
    logic exp_crosses;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        // long hold-off so the block fills and pushes back on its input
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (!rx_no_idle) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 19)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (crossing_q.size() == 0) begin
        $display("%0t unexpected item: expected none, actual crosses %0b",
                 $time, crosses_o);
        mismatch_count++;
      end else begin
        exp_crosses = crossing_q.pop_front();
        if (crosses_o !== exp_crosses) begin
          $display("%0t crosses mismatch: expected %0b, actual %0b",
                   $time, exp_crosses, crosses_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake on either side
  // ---------------------------------------------------------------------------

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

// File: files.f
hdl/segx_pkg.sv
hdl/segx_fifo.sv
hdl/segx_front.sv
hdl/segx_back.sv
hdl/segment_crossing_test.sv
verif/tb_segment_crossing_test.sv
